>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("sequence violated");

`endif

>>> sv/sem_pkg.sv
package sem_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam int CSR_BITS     = 13;
   localparam int FH_BITS      = 13;
   localparam int FH_MAX       = 4096;
   localparam int ROW_BITS     = 12;
   localparam int SUM_BITS     = 21;
   localparam int CLAMP_SQUARE = 65281;
   localparam logic [7:0] CLAMP_VALUE = 8'd255;

   typedef struct packed {
      logic       cmd;
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       window;
      logic       grad;
      logic       square;
      logic       root_step;
      logic [2:0] root_idx;
      logic       finish;
   } dp_cmd_type;

   typedef struct packed {
      logic ignore;
      logic emit;
      logic out_free;
   } dp_status_type;

endpackage

>>> sv/sem_ram.sv
module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/sem_ctrl.sv
`include "assert_macros.svh"
module sem_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sem_pkg::dp_status_type status,
   output sem_pkg::dp_cmd_type    cmd
);
   import sem_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WIN, ST_GRAD, ST_SQUARE, ST_ROOT, ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.ignore) begin
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            state_in = status.emit ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = ST_ROOT;
            cnt_in   = 3'd0;
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.load      = (state_ff == ST_IDLE) && req_valid && !status.ignore;
   assign cmd.window    = (state_ff == ST_WIN);
   assign cmd.grad      = (state_ff == ST_GRAD);
   assign cmd.square    = (state_ff == ST_SQUARE);
   assign cmd.root_step = (state_ff == ST_ROOT);
   assign cmd.root_idx  = cnt_ff;
   assign cmd.finish    = (state_ff == ST_FINISH) && status.out_free;

   `ASSERT_NEXT(a_load_to_win, clock, reset, cmd.load, state_ff == ST_WIN)
   `ASSERT_NEXT(a_root_to_finish, clock, reset,
      (state_ff == ST_ROOT) && (cnt_ff == 3'd7), state_ff == ST_FINISH)

endmodule

>>> sv/sem_datapath.sv
`include "assert_macros.svh"
module sem_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sem_pkg::req_type              req_data,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [sem_pkg::CSR_BITS-1:0]  csr_wdata,
   input  sem_pkg::dp_cmd_type           cmd,
   output sem_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sem_pkg::rsp_type              rsp_data
);
   import sem_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int LW_BITS  = $clog2(MAX_WIDTH + 1);

   logic [LW_BITS-1:0]  line_width_ff, line_width_in;
   logic [FH_BITS-1:0]  frame_height_ff, frame_height_in;
   logic [COL_BITS-1:0] in_col_ff, in_col_in;
   logic [FH_BITS-1:0]  in_row_ff, in_row_in;
   logic [COL_BITS-1:0] out_col_ff, out_col_in;
   logic [ROW_BITS-1:0] out_row_ff, out_row_in;

   logic [23:0] pix_ff;
   logic [23:0] up_rd, mid_rd;
   logic [23:0] win_ff [3][3];
   logic [23:0] win_in [3][3];
   logic [23:0] e_ff [3][3];
   logic [23:0] e_in [3][3];
   logic        last_ff, last_in;

   logic signed [11:0] gx_ff [3];
   logic signed [11:0] gy_ff [3];
   logic [SUM_BITS-1:0] s_ff [3];
   logic [7:0]          n_ff [3];
   logic [7:0]          mag [3];

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic [31:0] lw_v, fh_v;
   logic        emit;
   logic        out_col_end, out_row_end;

   function automatic logic [7:0] chan(input logic [23:0] px, input int ch);
      chan = px[8*ch +: 8];
   endfunction

   // Line stores: upper holds the row two back, middle the previous row.
   sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .we(cmd.window), .waddr(in_col_ff), .wdata(mid_rd),
      .raddr(in_col_ff), .rdata(up_rd)
   );
   sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .we(cmd.window), .waddr(in_col_ff), .wdata(pix_ff),
      .raddr(in_col_ff), .rdata(mid_rd)
   );

   assign out_col_end = ((LW_BITS'(out_col_ff) + LW_BITS'(1)) >= line_width_ff);
   assign out_row_end = ((FH_BITS'(out_row_ff) + FH_BITS'(1)) >= frame_height_ff);
   assign emit = ((in_row_ff >= FH_BITS'(2)) ||
                  ((in_row_ff == FH_BITS'(1)) && (in_col_ff != '0))) &&
                 (FH_BITS'(out_row_ff) < frame_height_ff);

   assign status.ignore   = (in_row_ff < frame_height_ff) && req_data.cmd;
   assign status.emit     = emit;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Window shift and border masking.
   always_comb begin
      win_in = win_ff;
      e_in   = win_ff;
      if (in_col_ff == '0) begin
         for (int r = 0; r < 3; r++) begin
            e_in[r][0]   = win_ff[r][1];
            e_in[r][1]   = win_ff[r][2];
            e_in[r][2]   = 24'd0;
            win_in[r][0] = 24'd0;
            win_in[r][1] = 24'd0;
         end
      end else begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
      end
      win_in[0][2] = up_rd;
      win_in[1][2] = mid_rd;
      win_in[2][2] = pix_ff;
      if (in_col_ff != '0) begin
         e_in = win_in;
      end
      for (int r = 0; r < 3; r++) begin
         if (out_col_ff == '0) e_in[r][0] = 24'd0;
         if (out_col_end) e_in[r][2] = 24'd0;
      end
      for (int r = 0; r < 3; r++) begin
         if (out_row_ff == '0) e_in[0][r] = 24'd0;
         if (out_row_end) e_in[2][r] = 24'd0;
      end
      last_in = out_row_end && out_col_end;
   end

   // Position counters and configuration.
   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      lw_v = 32'(csr_wdata[10:0]);
      if (lw_v == 32'd0) lw_v = 32'd1;
      if (lw_v > 32'(MAX_WIDTH)) lw_v = 32'(MAX_WIDTH);
      fh_v = 32'(csr_wdata[12:0]);
      if (fh_v == 32'd0) fh_v = 32'd1;
      if (fh_v > 32'(FH_MAX)) fh_v = 32'(FH_MAX);
      if (csr_we) begin
         case (csr_index)
            CSR_LINE_WIDTH: begin
               line_width_in = LW_BITS'(lw_v);
               in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = FH_BITS'(fh_v);
               in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
            end
            default: ;
         endcase
      end else if (cmd.window) begin
         if ((LW_BITS'(in_col_ff) + LW_BITS'(1)) >= line_width_ff) begin
            in_col_in = '0;
            if (in_row_ff <= frame_height_ff) in_row_in = in_row_ff + FH_BITS'(1);
         end else begin
            in_col_in = in_col_ff + COL_BITS'(1);
         end
      end else if (cmd.finish) begin
         if (last_ff) begin
            in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
         end else if (out_col_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_BITS'(1);
         end else begin
            out_col_in = out_col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LW_BITS'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
         frame_height_ff <= FH_BITS'(1024);
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
      end
   end

   // Magnitude pipeline: gradients, squares, eight-step root, rounding and clamping.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [15:0] nn;
         nn = 16'(n_ff[c]) * 16'(n_ff[c]);
         if (s_ff[c] >= SUM_BITS'(CLAMP_SQUARE)) begin
            mag[c] = CLAMP_VALUE;
         end else if (s_ff[c] > (SUM_BITS'(nn) + SUM_BITS'(n_ff[c]))) begin
            mag[c] = n_ff[c] + 8'd1;
         end else begin
            mag[c] = n_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff <= (in_row_ff < frame_height_ff) ?
                   {req_data.in_red, req_data.in_green, req_data.in_blue} : 24'd0;
      end
      if (cmd.window) begin
         win_ff  <= win_in;
         e_ff    <= e_in;
         last_ff <= last_in;
      end
      for (int c = 0; c < 3; c++) begin
         if (cmd.grad) begin
            gx_ff[c] <= $signed({1'b0, 11'(chan(e_ff[0][2], c)) +
                                       11'({chan(e_ff[1][2], c), 1'b0}) +
                                       11'(chan(e_ff[2][2], c))}) -
                        $signed({1'b0, 11'(chan(e_ff[0][0], c)) +
                                       11'({chan(e_ff[1][0], c), 1'b0}) +
                                       11'(chan(e_ff[2][0], c))});
            gy_ff[c] <= $signed({1'b0, 11'(chan(e_ff[2][0], c)) +
                                       11'({chan(e_ff[2][1], c), 1'b0}) +
                                       11'(chan(e_ff[2][2], c))}) -
                        $signed({1'b0, 11'(chan(e_ff[0][0], c)) +
                                       11'({chan(e_ff[0][1], c), 1'b0}) +
                                       11'(chan(e_ff[0][2], c))});
         end
         if (cmd.square) begin
            s_ff[c] <= SUM_BITS'(24'(gx_ff[c] * gx_ff[c]) + 24'(gy_ff[c] * gy_ff[c]));
            n_ff[c] <= 8'd0;
         end
         if (cmd.root_step) begin
            logic [7:0] t;
            t = n_ff[c] | (8'h80 >> cmd.root_idx);
            if (SUM_BITS'(16'(t) * 16'(t)) <= s_ff[c]) n_ff[c] <= t;
         end
      end
      if (cmd.finish) begin
         rsp_data_ff.out_blue  <= mag[0];
         rsp_data_ff.out_green <= mag[1];
         rsp_data_ff.out_red   <= mag[2];
         rsp_data_ff.frame_end <= last_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_in_col_range, clock, reset, LW_BITS'(in_col_ff) < line_width_ff)
   `ASSERT_ALWAYS(a_out_row_range, clock, reset,
      FH_BITS'(out_row_ff) < frame_height_ff)

endmodule

>>> sv/sobel_edge_magnitude_top.sv
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. Each
// request carries one pixel or a drain command; for every channel the block
// forms the Sobel Gx and Gy sums with out-of-frame neighbours taken as zero
// and returns round(sqrt(gx*gx + gy*gy)) clamped to 255, with frame_end set on
// the last pixel of the frame. A result leaves once the pixel below and to the
// right of it has arrived, so after the last pixel of a frame the user sends
// line_width + 1 drain requests to flush the remaining results. A request
// that yields no result passes through the line store read and then the
// window update; one that yields a result then also passes through the
// gradient, square, eight-step bit-serial square root (shared by nothing
// else and run per channel in parallel) and finish states before the next
// request is taken. A drain request that arrives before the frame is complete
// is taken and dropped. The result sits in an output register, so a
// waiting result does not stop the next request being taken; only a second
// result waits for the first to be collected. Writing either configuration
// register restarts the frame. The line stores are not cleared after reset:
// every entry that is read before it has been written in the current frame
// only feeds neighbours that lie outside the frame and are masked to zero.
module sobel_edge_magnitude_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  sem_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sem_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [sem_pkg::CSR_BITS-1:0] csr_wdata
);
   import sem_pkg::*;

   // Commands from the controller and status back from the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
